[design/pre_pkg.sv]
// ----------------------------------------------------------------------------
// pre_pkg: shared types and constants of the page replacement engine
// frame/page geometry, policy and status codes, controller command struct
// ----------------------------------------------------------------------------
`default_nettype none
package pre_pkg;
  localparam int Frames = 16;
  localparam int Pages = 64;
  localparam int FrameW = 4;
  localparam int PageW = 7;
  localparam int CntW = 5;

  typedef enum logic [1:0] {
    POL_FIFO  = 2'd0,
    POL_LRU   = 2'd1,
    POL_CLOCK = 2'd2,
    POL_RSVD  = 2'd3
  } policy_t;

  typedef enum logic [1:0] {
    ST_HIT   = 2'd0,
    ST_FREE  = 2'd1,
    ST_EVICT = 2'd2,
    ST_INVAL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_POLICY = 2'd0,
    REG_FRAMES = 2'd1,
    REG_PAGES  = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_SCAN, S_SWEEP, S_COMMIT, S_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture page, classify
    logic scan_init; // start lru scan / clock sweep
    logic scan_step; // one frame per cycle
    logic commit;    // update tables
  } cmd_t;

  typedef struct packed {
    logic    invalid;
    logic    hit;
    logic    free_ok;
    policy_t pol;
    logic    scan_done;
  } sts_t;
endpackage
`default_nettype wire

[design/pre_if.sv]
// ----------------------------------------------------------------------------
// pre_if: valid/ready channel
// generic payload width, source and sink modports
// ----------------------------------------------------------------------------
`default_nettype none
interface pre_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[design/pre_ctrl.sv]
// ----------------------------------------------------------------------------
// pre_ctrl: controller of the page replacement engine
// sequences lookup, victim scan, commit and result handoff
// ----------------------------------------------------------------------------
`default_nettype none
module pre_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_free,
  input  wire pre_pkg::sts_t sts,
  output pre_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_load
);
  pre_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pre_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pre_pkg::S_IDLE: if (in_fire) state_nxt = pre_pkg::S_LOOK;
      pre_pkg::S_LOOK: begin
        if (sts.invalid || sts.hit || sts.free_ok) state_nxt = pre_pkg::S_COMMIT;
        else if (sts.pol == pre_pkg::POL_LRU) state_nxt = pre_pkg::S_SCAN;
        else if (sts.pol == pre_pkg::POL_CLOCK) state_nxt = pre_pkg::S_SWEEP;
        else state_nxt = pre_pkg::S_COMMIT;
      end
      pre_pkg::S_SCAN, pre_pkg::S_SWEEP:
        if (sts.scan_done) state_nxt = pre_pkg::S_COMMIT;
      pre_pkg::S_COMMIT: state_nxt = pre_pkg::S_OUT;
      pre_pkg::S_OUT: if (out_free) state_nxt = pre_pkg::S_IDLE;
      default: state_nxt = pre_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    out_load = 1'b0;
    unique case (state_r)
      pre_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      pre_pkg::S_LOOK: cmd.scan_init = 1'b1;
      pre_pkg::S_SCAN, pre_pkg::S_SWEEP: cmd.scan_step = 1'b1;
      pre_pkg::S_COMMIT: cmd.commit = 1'b1;
      pre_pkg::S_OUT: out_load = out_free;
      default: busy = 1'b1;
    endcase
  end
endmodule
`default_nettype wire

[design/pre_dp.sv]
// ----------------------------------------------------------------------------
// pre_dp: datapath of the page replacement engine
// page map memory, frame tables, victim scan and fault counter
// ----------------------------------------------------------------------------
`default_nettype none
module pre_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pre_pkg::cmd_t                 cmd,
  input  wire logic [7:0]                    in_page,
  input  wire logic                          cfg_en,
  input  wire logic [1:0]                    cfg_idx,
  input  wire logic [6:0]                    cfg_data,
  output pre_pkg::sts_t                      sts,
  output logic [1:0]                         res_status,
  output logic [pre_pkg::FrameW-1:0]         res_frame,
  output logic [pre_pkg::PageW-1:0]          res_evicted,
  output logic [15:0]                        res_faults
);
  localparam int FW = pre_pkg::FrameW;
  localparam int PW = pre_pkg::PageW;
  localparam int CW = pre_pkg::CntW;
  localparam int NF = pre_pkg::Frames;
  localparam int NP = pre_pkg::Pages;

  logic [1:0]  pol_r;
  logic [4:0]  nfr_r;
  logic [6:0]  npg_r;

  logic [NP-1:0]  res_r;                   // resident bits, reset clears
  logic [FW-1:0]  pfr_r [NP];              // page -> frame
  logic [PW-1:0]  own_r [NF];
  logic [NF-1:0]  ref_r;
  logic [FW-1:0]  rank_r [NF];
  logic [CW-1:0]  filled_r;
  logic [FW-1:0]  fifo_r, hand_r;
  logic [15:0]    faults_r;

  logic [7:0]     page_r;
  logic [PW-1:0]  pidx_r;
  logic           inval_r, hit_r;
  logic [FW-1:0]  hitfr_r;
  logic [CW-1:0]  limit_r;
  logic [FW-1:0]  vic_r, scan_r, best_r;
  logic [CW-1:0]  step_r;
  logic           done_r;

  logic [CW-1:0]  limit_c;
  logic [6:0]     maxp_c;
  logic [FW-1:0]  hnext_c, hcur_c, frame_c;
  logic           free_c;
  logic [5:0]     pslot_c;

  always_comb begin
    if (nfr_r == '0) limit_c = CW'(1);
    else if (nfr_r > CW'(NF)) limit_c = CW'(NF);
    else limit_c = nfr_r;
    maxp_c = (npg_r < 7'(NP)) ? npg_r : 7'(NP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r <= pre_pkg::POL_FIFO;
      nfr_r <= 5'd16;
      npg_r <= 7'd64;
    end else if (cfg_en) begin
      unique case (pre_pkg::reg_idx_t'(cfg_idx))
        pre_pkg::REG_POLICY: pol_r <= cfg_data[1:0];
        pre_pkg::REG_FRAMES: nfr_r <= cfg_data[4:0];
        pre_pkg::REG_PAGES:  npg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign free_c = filled_r < limit_r;
  assign hcur_c = (scan_r + FW'(1) < FW'(limit_r) || CW'(scan_r) + CW'(1) < limit_r)
                  ? scan_r + FW'(1) : '0;
  assign hnext_c = (CW'(vic_r) + CW'(1) < limit_r) ? vic_r + FW'(1) : '0;
  assign pslot_c = 6'(in_page - 8'd1);

  always_comb begin
    if (hit_r) frame_c = hitfr_r;
    else if (free_c) frame_c = filled_r[FW-1:0];
    else frame_c = vic_r;
  end

  assign sts.invalid = inval_r;
  assign sts.hit = hit_r;
  assign sts.free_ok = free_c;
  assign sts.pol = pre_pkg::policy_t'(pol_r);
  assign sts.scan_done = done_r;

  // request capture and lookup
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r  <= in_page;
      pidx_r  <= PW'(in_page - 8'd1);
      inval_r <= (in_page == 8'd0) || (in_page > {1'b0, maxp_c});
      limit_r <= limit_c;
    end
    if (cmd.load) begin
      hit_r   <= res_r[pslot_c] && in_page != 8'd0
                 && in_page <= {1'b0, maxp_c};
      hitfr_r <= pfr_r[pslot_c];
    end
  end

  // victim selection: fifo picked directly, lru and clock one frame a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r  <= '0;
      fifo_r <= '0;
      hand_r <= '0;
      done_r <= 1'b0;
    end else if (cmd.scan_init) begin
      done_r <= 1'b0;
      step_r <= CW'(1);
      best_r <= '0;
      if (pol_r == pre_pkg::POL_CLOCK)
        scan_r <= (CW'(hand_r) < limit_r) ? hand_r : '0;
      else begin
        scan_r <= '0;
        vic_r  <= (CW'(fifo_r) < limit_r) ? fifo_r : '0;
      end
      if (limit_r == CW'(1)) best_r <= '0;
    end else if (cmd.scan_step) begin
      if (pol_r == pre_pkg::POL_LRU) begin
        if (step_r >= limit_r) begin
          done_r <= 1'b1;
          vic_r  <= best_r;
        end else begin
          if (rank_r[step_r[FW-1:0]] > rank_r[best_r]) best_r <= step_r[FW-1:0];
          step_r <= step_r + CW'(1);
        end
      end else if (!done_r) begin
        if (ref_r[scan_r]) begin
          ref_r[scan_r] <= 1'b0;
          scan_r <= hcur_c;
        end else begin
          vic_r  <= scan_r;
          done_r <= 1'b1;
        end
      end
    end else if (cmd.commit && !inval_r) begin
      done_r <= 1'b0;
      if (hit_r) ref_r[hitfr_r] <= 1'b1;
      else begin
        ref_r[frame_c] <= 1'b0;
        if (!free_c) begin
          if (pol_r == pre_pkg::POL_CLOCK) hand_r <= hnext_c;
          else if (pol_r != pre_pkg::POL_LRU) fifo_r <= hnext_c;
        end
      end
    end else if (cmd.commit) done_r <= 1'b0;
  end

  // table update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r    <= '0;
      filled_r <= '0;
      faults_r <= '0;
      for (int i = 0; i < NF; i++) rank_r[i] <= '0;
    end else if (cmd.commit && !inval_r) begin
      for (int i = 0; i < NF; i++) begin
        if (FW'(i) == frame_c) rank_r[i] <= '0;
        else if (CW'(i) < filled_r + CW'(!hit_r && free_c)) begin
          if (!hit_r && free_c) begin
            if (CW'(rank_r[i]) < filled_r + CW'(1)) rank_r[i] <= rank_r[i] + FW'(1);
          end else if (rank_r[i] < rank_r[frame_c]) rank_r[i] <= rank_r[i] + FW'(1);
        end
      end
      if (!hit_r) begin
        if (!free_c && own_r[frame_c] >= PW'(1) && own_r[frame_c] <= PW'(NP))
          res_r[6'(own_r[frame_c] - PW'(1))] <= 1'b0;
        res_r[pidx_r[5:0]] <= 1'b1;
        if (free_c) filled_r <= filled_r + CW'(1);
        if (faults_r != 16'hffff) faults_r <= faults_r + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !inval_r && !hit_r) begin
      own_r[frame_c] <= page_r[PW-1:0];
      pfr_r[pidx_r[5:0]] <= frame_c;
    end
  end

  // result word, sampled at commit (fault count of this item included)
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (inval_r) begin
        res_status  <= pre_pkg::ST_INVAL;
        res_frame   <= '0;
        res_evicted <= '0;
        res_faults  <= faults_r;
      end else begin
        res_status  <= hit_r ? pre_pkg::ST_HIT : (free_c ? pre_pkg::ST_FREE : pre_pkg::ST_EVICT);
        res_frame   <= frame_c;
        res_evicted <= (hit_r || free_c) ? '0 : own_r[frame_c];
        res_faults  <= (hit_r || faults_r == 16'hffff) ? faults_r : faults_r + 16'd1;
      end
    end
  end
endmodule
`default_nettype wire

[design/page_replacement_engine.sv]
// ----------------------------------------------------------------------------
// page_replacement_engine: demand-paging frame allocator
// fifo, lru and clock second-chance victim choice over up to 16 frames
// ----------------------------------------------------------------------------
// sequence: page word taken in idle, then lookup, then for an lru or clock eviction a
//   victim scan, then commit to the tables and handoff to the output register;
//   lru scans each frame up to the frame limit, clock sweeps past set reference bits
// flow: one word in flight; next word taken the cycle after the result
//   enters the output register, which waits while the output is stalled
// reset: rst_n synchronous, clears resident bits, ranks, counters; registers to defaults
`default_nettype none
module page_replacement_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pre_if.sink              in_ch,
  pre_if.source            out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [6:0]  cfg_wdata
);
  pre_pkg::cmd_t cmd;
  pre_pkg::sts_t sts;
  logic busy, out_load, in_fire, out_free;
  logic [1:0]  r_status;
  logic [3:0]  r_frame;
  logic [6:0]  r_evict;
  logic [15:0] r_faults;
  logic        ovalid_r;
  logic [28:0] odata_r;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && !busy;
  // output register frees when empty or being taken
  assign out_free = !ovalid_r || out_ch.ready;

  pre_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_free, .sts, .cmd, .busy, .out_load
  );

  pre_dp u_dp (
    .clk, .rst_n, .cmd,
    .in_page(in_ch.data),
    .cfg_en(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_wdata),
    .sts,
    .res_status(r_status), .res_frame(r_frame),
    .res_evicted(r_evict), .res_faults(r_faults)
  );

  // output word: {status, frame_index, evicted_page, fault_total}
  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (out_load) ovalid_r <= 1'b1;
    else if (out_ch.ready) ovalid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (out_load) odata_r <= {r_status, r_frame, r_evict, r_faults};
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;
endmodule
`default_nettype wire

[tb/sv/page_replacement_engine_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_replacement_engine_test: self-checking bench for the frame allocator
// drives page references with random gaps, predicts hit, free-frame fault,
// eviction and invalid outcomes under fifo, lru and clock policies, and checks
// every result word against the prediction while the receiver stalls at random
// ----------------------------------------------------------------------------
module page_replacement_engine_test;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles = 40;   // longest eviction latency plus margin

  typedef struct packed {
    pre_pkg::status_t st;
    logic [3:0]       frame;
    logic [6:0]       evicted;
    logic [15:0]      faults;
  } outcome_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  pre_pkg::reg_idx_t cfg_index;
  logic [6:0]        cfg_wdata;

  pre_if #(8)  in_ch ();
  pre_if #(29) out_ch ();

  page_replacement_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock, 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---- shadow copy of the allocator ----
  int unsigned mode_q;
  int unsigned frames_q;
  int unsigned pages_q;
  int unsigned resident [pre_pkg::Pages];
  int unsigned home_frame [pre_pkg::Pages];
  int unsigned owner [pre_pkg::Frames];
  int unsigned refbit [pre_pkg::Frames];
  int unsigned rank [pre_pkg::Frames];
  int unsigned filled;
  int unsigned fifo_ptr;
  int unsigned hand;
  int unsigned fault_count;

  outcome_t pending_results [$];
  int       mismatches;
  int       idle_cycles;
  int       send_gap;
  bit       valid_kept;

  function automatic void shadow_reset();
    mode_q = pre_pkg::POL_FIFO;
    frames_q = 16;
    pages_q = 64;
    foreach (resident[i]) begin
      resident[i] = 0;
      home_frame[i] = 0;
    end
    foreach (owner[i]) begin
      owner[i] = 0;
      refbit[i] = 0;
      rank[i] = 0;
    end
    filled = 0;
    fifo_ptr = 0;
    hand = 0;
    fault_count = 0;
  endfunction

  // move frame f to most recent, aging the younger filled frames
  function automatic void mark_recent(int unsigned f);
    int unsigned r;
    r = rank[f];
    for (int unsigned j = 0; j < filled && j < pre_pkg::Frames; j++)
      if (j != f && rank[j] < r) rank[j]++;
    rank[f] = 0;
  endfunction

  // work out the outcome of one page reference and advance the shadow state
  function automatic outcome_t allocate_page(int unsigned p);
    outcome_t    o;
    int unsigned maxp, lim, fr, ev, st, h, best, old;
    maxp = pages_q < pre_pkg::Pages ? pages_q : pre_pkg::Pages;
    lim = frames_q == 0 ? 1 : frames_q;
    if (lim > pre_pkg::Frames) lim = pre_pkg::Frames;
    fr = 0;
    ev = 0;
    if (p == 0 || p > maxp) begin
      st = pre_pkg::ST_INVAL;
    end else if (resident[p-1]) begin
      st = pre_pkg::ST_HIT;
      fr = home_frame[p-1] % pre_pkg::Frames;
      refbit[fr] = 1;
      mark_recent(fr);
    end else begin
      if (filled < lim) begin
        st = pre_pkg::ST_FREE;
        fr = filled;
        filled++;
        rank[fr] = filled;
        mark_recent(fr);
      end else begin
        st = pre_pkg::ST_EVICT;
        if (mode_q == pre_pkg::POL_LRU) begin
          best = 0;
          for (int unsigned j = 1; j < lim; j++)
            if (rank[j] > rank[best]) best = j;
          fr = best;
        end else if (mode_q == pre_pkg::POL_CLOCK) begin
          // second chance: clear set bits until a clear one turns up
          h = hand < lim ? hand : 0;
          for (int unsigned s = 0; s < 2 * lim; s++) begin
            if (refbit[h] == 0) break;
            refbit[h] = 0;
            h = (h + 1 < lim) ? h + 1 : 0;
          end
          hand = (h + 1 < lim) ? h + 1 : 0;
          fr = h;
        end else begin
          // fifo, also taken by the unused policy code
          fr = fifo_ptr < lim ? fifo_ptr : 0;
          fifo_ptr = (fr + 1 < lim) ? fr + 1 : 0;
        end
        old = owner[fr];
        if (old >= 1 && old <= pre_pkg::Pages) resident[old-1] = 0;
        ev = old;
        mark_recent(fr);
      end
      owner[fr] = p;
      refbit[fr] = 0;
      resident[p-1] = 1;
      home_frame[p-1] = fr;
      if (fault_count < 16'hFFFF) fault_count++;
    end
    o.st = pre_pkg::status_t'(st[1:0]);
    o.frame = fr[3:0];
    o.evicted = ev[6:0];
    o.faults = fault_count[15:0];
    return o;
  endfunction

  // ---- stimulus helpers ----

  // one register write while the engine is idle
  task automatic write_reg(pre_pkg::reg_idx_t idx, int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pre_pkg::REG_POLICY: mode_q = value & 3;
      pre_pkg::REG_FRAMES: frames_q = value & 31;
      pre_pkg::REG_PAGES:  pages_q = value & 127;
      default: ;
    endcase
  endtask

  // send one page reference word; valid stays up when the next gap is zero
  task automatic send_page(int unsigned p);
    repeat (send_gap) @(posedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data <= p[7:0];
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(allocate_page(p & 255));
    send_gap = $urandom_range(0, 10);
    if ($urandom_range(0, 7) == 0) send_gap = 0;
    valid_kept = (send_gap == 0);
    if (!valid_kept) in_ch.valid <= 1'b0;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain();
    if (valid_kept) begin
      in_ch.valid <= 1'b0;
      valid_kept = 0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // random page, mostly from a small working set so policies get exercised
  function automatic int unsigned pick_page();
    int unsigned maxp, lim, span;
    maxp = pages_q < pre_pkg::Pages ? pages_q : pre_pkg::Pages;
    lim = frames_q == 0 ? 1 : (frames_q > pre_pkg::Frames ? pre_pkg::Frames : frames_q);
    if (maxp == 0 || $urandom_range(0, 99) < 12) return $urandom_range(0, 255);
    span = lim + $urandom_range(0, 5);
    if (span > maxp) span = maxp;
    return $urandom_range(1, span);
  endfunction

  task automatic run_random(int count);
    repeat (count) send_page(pick_page());
    drain();
  endtask

  // ---- test tasks ----

  // defaults: invalid pages, every input bit, free fills, hits, fifo eviction
  task automatic test_defaults();
    int unsigned seq [] = '{0, 255, 65, 128, 64, 1, 1, 2, 3, 170, 85,
                            4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17};
    foreach (seq[i]) send_page(seq[i]);
    drain();
  endtask

  // lru with four frames: re-used pages must survive eviction
  task automatic test_lru();
    int unsigned seq [] = '{1, 2, 3, 4, 1, 2, 5, 1, 6, 2, 7, 3, 1};
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_LRU);
    write_reg(pre_pkg::REG_FRAMES, 4);
    write_reg(pre_pkg::REG_PAGES, 8);
    foreach (seq[i]) send_page(seq[i]);
    drain();
    run_random(120);
  endtask

  // clock second chance, including a sweep over all set bits
  task automatic test_clock();
    int unsigned seq [] = '{1, 2, 3, 4, 5, 1, 2, 3, 4, 5, 6, 7, 2, 8};
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_CLOCK);
    write_reg(pre_pkg::REG_FRAMES, 5);
    write_reg(pre_pkg::REG_PAGES, 64);
    foreach (seq[i]) send_page(seq[i]);
    drain();
    run_random(120);
  endtask

  // out-of-range register values: reserved policy, zero and oversized counts
  task automatic test_extremes();
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_RSVD);
    write_reg(pre_pkg::REG_FRAMES, 0);
    write_reg(pre_pkg::REG_PAGES, 127);
    run_random(80);
    write_reg(pre_pkg::REG_FRAMES, 31);
    write_reg(pre_pkg::REG_PAGES, 0);
    run_random(30);
    write_reg(pre_pkg::REG_PAGES, 1);
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_LRU);
    run_random(40);
    write_reg(pre_pkg::REG_FRAMES, 16);
    write_reg(pre_pkg::REG_PAGES, 64);
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_CLOCK);
    run_random(100);
  endtask

  // fill many frames, then lower the count: high frames still hit
  task automatic test_frames_lowered();
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_FIFO);
    write_reg(pre_pkg::REG_FRAMES, 16);
    write_reg(pre_pkg::REG_PAGES, 40);
    for (int unsigned p = 20; p < 36; p++) send_page(p);
    drain();
    write_reg(pre_pkg::REG_FRAMES, 3);
    for (int unsigned p = 20; p < 36; p++) send_page(p);
    drain();
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_CLOCK);
    run_random(60);
    write_reg(pre_pkg::REG_POLICY, pre_pkg::POL_LRU);
    run_random(60);
  endtask

  // random settings, changed between phases while idle
  task automatic test_random_phases();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(pre_pkg::REG_POLICY, $urandom_range(0, 3));
      write_reg(pre_pkg::REG_FRAMES, ph == 0 ? 1 : $urandom_range(1, 16));
      write_reg(pre_pkg::REG_PAGES, ph == 1 ? 64 : $urandom_range(2, 64));
      run_random(ph == 3 ? 0 : 90);
    end
  endtask

  // ---- result checker with random back-pressure ----
  initial begin
    outcome_t want, got;
    int       stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got = out_ch.data;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d frame %0d evicted %0d faults %0d",
                   got.st, got.frame, got.evicted, got.faults);
      end else begin
        want = pending_results.pop_front();
        if (got.st !== want.st || got.frame !== want.frame ||
            got.evicted !== want.evicted || got.faults !== want.faults) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st %0d fr %0d ev %0d ft %0d,",
                      " got st %0d fr %0d ev %0d ft %0d"},
                     want.st, want.frame, want.evicted, want.faults,
                     got.st, got.frame, got.evicted, got.faults);
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("page_replacement_engine_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---- main sequence ----
  initial begin
    mismatches = 0;
    idle_cycles = 0;
    send_gap = 0;
    valid_kept = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= pre_pkg::REG_POLICY;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    shadow_reset();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_lru();
    test_clock();
    test_extremes();
    test_frames_lowered();
    test_random_phases();

    // leftover predictions are failures too
    mismatches += pending_results.size();
    if (mismatches == 0) begin
      $display("page_replacement_engine_test: done, clean");
    end else begin
      $display("page_replacement_engine_test: done, errors");
    end
    $finish;
  end
endmodule
